@@ rtl/core/acrs_pkg.sv @@
// shared widths, register indexes and constants of the count-rate smoother
package acrs_pkg;

   localparam int COUNT_W    = 16;
   localparam int FRAC_W     = 8;
   localparam int SAMPLE_W   = 24;
   localparam int DOSE_W     = 32;
   localparam int DISP_W     = 32;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int STREAK_W   = 3;
   localparam int DEN_W      = 8;
   localparam int PROD_W     = SAMPLE_W + DOSE_W;
   localparam int SCALED_W   = PROD_W - 16;
   localparam int WIDE_W     = SCALED_W + 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UNIT_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DOSE       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND = 2'd3;

   // unit modes, any other code acts as scaled
   localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DOSE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SCALED = 2'd2;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 24'd2560;
   localparam logic [DOSE_W-1:0]   DOSE_RESET      = 32'd65536;

   // times 1.16 as 116 / 100
   localparam logic [DEN_W-1:0] SCALE_DEN = 8'd100;

   localparam logic [DISP_W-1:0] DISP_MAX = {DISP_W{1'b1}};

endpackage

@@ rtl/core/acrs_if.sv @@
// item channels of the count-rate smoother
interface acrs_req_if;
   logic                        valid;
   logic                        ready;
   logic [acrs_pkg::COUNT_W-1:0] pulse_count;
   modport source (output valid, output pulse_count, input ready);
   modport sink (input valid, input pulse_count, output ready);
endinterface

interface acrs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [acrs_pkg::SAMPLE_W-1:0] smoothed_rate;
   logic [acrs_pkg::DISP_W-1:0]   display_value;
   logic                          window_refreshed;
   modport source (output valid, output smoothed_rate, output display_value,
                   output window_refreshed, input ready);
   modport sink (input valid, input smoothed_rate, input display_value,
                 input window_refreshed, output ready);
endinterface

@@ rtl/core/acrs_ram.sv @@
// generic single-write, single-read ram with registered read
module acrs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 60
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/acrs_sdiv.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module acrs_sdiv #(
   parameter int DW = 47,
   parameter int VW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW);

   logic [DW-1:0] num_ff, num_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] den_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic          take;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, num_ff[DW-1]};
      take    = trial >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DW-2:0], take};
         rem_in = take ? VW'(trial - {1'b0, den_ff}) : VW'(trial);
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

@@ rtl/core/acrs_smul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
module acrs_smul #(
   parameter int AW = 24,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [AW+BW-1:0] product
);

   localparam int CW = $clog2(AW);

   logic [AW-1:0]    a_ff;
   logic [BW-1:0]    b_ff;
   logic [AW+BW-1:0] acc_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // msb first: shift the sum and add b where the bit is set
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(AW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         a_ff   <= {a_ff[AW-2:0], 1'b0};
         acc_ff <= {acc_ff[AW+BW-2:0], 1'b0}
                   + (a_ff[AW-1] ? (AW+BW)'(b_ff) : '0);
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ rtl/core/adaptive_count_rate_smoother.sv @@
// top level: moving-average count-rate smoother with fast response
// One pulse count is taken per item and one result is returned per item. Items are
// handled one at a time: a decision step, then a ring update (or, when a streak
// overflows, a refill of the whole window), and the window average comes from a
// bit-serial divider. In raw mode the item then finishes; in dose modes a bit-serial
// multiply follows, and in the times-1.16 mode a second division. The finished
// result sits in an output register, so a new item is taken while it waits. Window
// entries never written since reset read as zero through per-entry valid bits.
module adaptive_count_rate_smoother #(
   parameter int WINDOW_LEN   = 60,
   parameter int STREAK_LIMIT = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   acrs_req_if.sink                            req_if,
   acrs_rsp_if.source                          rsp_if,
   input  logic                                csr_wr_en,
   input  logic [acrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [acrs_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int PW    = $clog2(WINDOW_LEN);
   localparam int SUM_W = acrs_pkg::SAMPLE_W + $clog2(WINDOW_LEN + 1);
   localparam int DIV_W = (SUM_W > acrs_pkg::WIDE_W) ? SUM_W : acrs_pkg::WIDE_W;
   localparam int SW    = acrs_pkg::STREAK_W;
   localparam int CMP_W = acrs_pkg::SAMPLE_W + 4;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_DECIDE   = 12'b0000_0000_0010,
      ST_READ     = 12'b0000_0000_0100,
      ST_FILL     = 12'b0000_0000_1000,
      ST_AVG_GO   = 12'b0000_0001_0000,
      ST_AVG_WAIT = 12'b0000_0010_0000,
      ST_MUL_GO   = 12'b0000_0100_0000,
      ST_MUL_WAIT = 12'b0000_1000_0000,
      ST_SCALE    = 12'b0001_0000_0000,
      ST_DIV_GO   = 12'b0010_0000_0000,
      ST_DIV_WAIT = 12'b0100_0000_0000,
      ST_FINISH   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [acrs_pkg::SAMPLE_W-1:0] thr_ff, bg_ff;
   logic [acrs_pkg::MODE_W-1:0]   mode_ff;
   logic [acrs_pkg::DOSE_W-1:0]   dose_ff;

   logic [acrs_pkg::SAMPLE_W-1:0] s_ff, last_avg_ff, avg_ff, push_ff;
   logic [SUM_W-1:0]              sum_ff;
   logic [PW-1:0]                 wpos_ff, fill_ff;
   logic [WINDOW_LEN-1:0]         valid_ff;
   logic [SW-1:0]                 rise_ff, fall_ff, ret_ff;
   logic [SW-1:0]                 rise_in, fall_in, ret_in;
   logic [acrs_pkg::WIDE_W-1:0]   val_ff;
   logic                          refresh_ff;

   logic                          rsp_valid_ff;
   logic [acrs_pkg::SAMPLE_W-1:0] rsp_rate_ff;
   logic [acrs_pkg::DISP_W-1:0]   rsp_disp_ff;
   logic                          rsp_ref_ff;

   logic                          accept;
   logic                          out_free;

   // decision signals
   logic [CMP_W-1:0] s10, a13, a7;
   logic             low, do_step, do_fill;
   logic [SW:0]      step_n;
   logic [SW-1:0]    step_cur;

   // ram and arithmetic units
   logic                          ram_we;
   logic [PW-1:0]                 ram_waddr;
   logic [acrs_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata, old_val;
   logic                          div_start, div_done;
   logic [DIV_W-1:0]              div_num, div_quot;
   logic [acrs_pkg::DEN_W-1:0]    div_den;
   logic                          mul_start, mul_done;
   logic [acrs_pkg::PROD_W-1:0]   mul_prod;
   logic [acrs_pkg::SCALED_W-1:0] scaled;
   logic [acrs_pkg::SAMPLE_W-1:0] avg_sat;

   assign accept    = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= acrs_pkg::THRESHOLD_RESET;
         mode_ff <= acrs_pkg::MODE_RAW;
         dose_ff <= acrs_pkg::DOSE_RESET;
         bg_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            acrs_pkg::REG_THRESHOLD:  thr_ff  <= csr_wr_data[acrs_pkg::SAMPLE_W-1:0];
            acrs_pkg::REG_UNIT_MODE:  mode_ff <= csr_wr_data[acrs_pkg::MODE_W-1:0];
            acrs_pkg::REG_DOSE:       dose_ff <= csr_wr_data;
            acrs_pkg::REG_BACKGROUND: bg_ff   <= csr_wr_data[acrs_pkg::SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // rise / fall / return decision against the last average
   always_comb begin
      s10 = (CMP_W'(s_ff) << 3) + (CMP_W'(s_ff) << 1);
      a13 = (CMP_W'(last_avg_ff) << 3) + (CMP_W'(last_avg_ff) << 2) + CMP_W'(last_avg_ff);
      a7  = (CMP_W'(last_avg_ff) << 3) - CMP_W'(last_avg_ff);
      low = s_ff < thr_ff;
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      ret_in   = ret_ff;
      do_step  = 1'b0;
      step_cur = '0;
      if (low) begin
         rise_in = '0;
         fall_in = '0;
         if (last_avg_ff > thr_ff) begin
            do_step  = 1'b1;
            step_cur = ret_ff;
         end
      end else begin
         ret_in = '0;
         if (s10 > a13) begin
            fall_in  = '0;
            do_step  = 1'b1;
            step_cur = rise_ff;
         end else if (s10 < a7) begin
            rise_in  = '0;
            do_step  = 1'b1;
            step_cur = fall_ff;
         end
      end
      step_n  = {1'b0, step_cur} + (SW+1)'(1);
      do_fill = do_step && (step_n > (SW+1)'(STREAK_LIMIT));
      if (do_step) begin
         if (low) begin
            ret_in = do_fill ? '0 : step_n[SW-1:0];
         end else if (s10 > a13) begin
            rise_in = do_fill ? '0 : step_n[SW-1:0];
         end else begin
            fall_in = do_fill ? '0 : step_n[SW-1:0];
         end
      end
   end

   // window ring
   assign old_val   = valid_ff[wpos_ff] ? ram_rdata : '0;
   assign ram_we    = (state_ff == ST_READ) || (state_ff == ST_FILL);
   assign ram_waddr = (state_ff == ST_FILL) ? fill_ff : wpos_ff;
   assign ram_wdata = (state_ff == ST_FILL) ? s_ff : push_ff;

   acrs_ram #(
      .WIDTH(acrs_pkg::SAMPLE_W),
      .DEPTH(WINDOW_LEN)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(wpos_ff),
      .rd_data(ram_rdata)
   );

   // shared divider: window length for the average, 100 for the 1.16 scale
   assign div_start = (state_ff == ST_AVG_GO) || (state_ff == ST_DIV_GO);
   assign div_num   = (state_ff == ST_AVG_GO) ? DIV_W'(sum_ff) : DIV_W'(val_ff);
   assign div_den   = (state_ff == ST_AVG_GO) ? acrs_pkg::DEN_W'(WINDOW_LEN)
                                              : acrs_pkg::SCALE_DEN;

   acrs_sdiv #(
      .DW(DIV_W),
      .VW(acrs_pkg::DEN_W)
   ) u_sdiv (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .done    (div_done),
      .quotient(div_quot)
   );

   assign mul_start = (state_ff == ST_MUL_GO);

   acrs_smul #(
      .AW(acrs_pkg::SAMPLE_W),
      .BW(acrs_pkg::DOSE_W)
   ) u_smul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (avg_ff),
      .b      (dose_ff),
      .done   (mul_done),
      .product(mul_prod)
   );

   assign avg_sat = (|div_quot[DIV_W-1:acrs_pkg::SAMPLE_W]) ? '1
                                                            : div_quot[acrs_pkg::SAMPLE_W-1:0];
   assign scaled  = mul_prod[acrs_pkg::PROD_W-1:16];

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_DECIDE;
         ST_DECIDE:   state_in = do_fill ? ST_FILL : ST_READ;
         ST_READ:     state_in = ST_AVG_GO;
         ST_FILL:     if (fill_ff == PW'(WINDOW_LEN - 1)) state_in = ST_AVG_GO;
         ST_AVG_GO:   state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_done) begin
               state_in = (mode_ff == acrs_pkg::MODE_RAW) ? ST_FINISH : ST_MUL_GO;
            end
         end
         ST_MUL_GO:   state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = (mode_ff == acrs_pkg::MODE_DOSE) ? ST_SCALE : ST_FINISH;
            end
         end
         ST_SCALE:    state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_FINISH;
         ST_FINISH:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sum_ff      <= '0;
         wpos_ff     <= '0;
         valid_ff    <= '0;
         last_avg_ff <= '0;
         rise_ff     <= '0;
         fall_ff     <= '0;
         ret_ff      <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_DECIDE: begin
               rise_ff <= rise_in;
               fall_ff <= fall_in;
               ret_ff  <= ret_in;
               fill_ff <= '0;
               if (do_fill) begin
                  sum_ff <= '0;
               end
            end
            ST_READ: begin
               sum_ff            <= sum_ff - SUM_W'(old_val) + SUM_W'(push_ff);
               valid_ff[wpos_ff] <= 1'b1;
               wpos_ff <= (wpos_ff == PW'(WINDOW_LEN - 1)) ? '0 : wpos_ff + PW'(1);
            end
            ST_FILL: begin
               sum_ff            <= sum_ff + SUM_W'(s_ff);
               valid_ff[fill_ff] <= 1'b1;
               fill_ff           <= fill_ff + PW'(1);
            end
            ST_AVG_WAIT: begin
               if (div_done) begin
                  last_avg_ff <= avg_sat;
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s_ff <= {req_if.pulse_count, {acrs_pkg::FRAC_W{1'b0}}};
      end
      if (state_ff == ST_DECIDE) begin
         refresh_ff <= do_fill;
         push_ff    <= do_step ? last_avg_ff : s_ff;
      end
      if ((state_ff == ST_AVG_WAIT) && div_done) begin
         avg_ff <= avg_sat;
         val_ff <= acrs_pkg::WIDE_W'(avg_sat);
      end
      if ((state_ff == ST_MUL_WAIT) && mul_done) begin
         val_ff <= (scaled > acrs_pkg::SCALED_W'(bg_ff))
                   ? acrs_pkg::WIDE_W'(scaled - acrs_pkg::SCALED_W'(bg_ff))
                   : acrs_pkg::WIDE_W'(scaled);
      end
      // times 116 as 64 + 32 + 16 + 4
      if (state_ff == ST_SCALE) begin
         val_ff <= (val_ff << 6) + (val_ff << 5) + (val_ff << 4) + (val_ff << 2);
      end
      if ((state_ff == ST_DIV_WAIT) && div_done) begin
         val_ff <= div_quot[acrs_pkg::WIDE_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_rate_ff <= avg_ff;
         rsp_disp_ff <= (|val_ff[acrs_pkg::WIDE_W-1:acrs_pkg::DISP_W])
                        ? acrs_pkg::DISP_MAX : val_ff[acrs_pkg::DISP_W-1:0];
         rsp_ref_ff  <= refresh_ff;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.smoothed_rate    = rsp_rate_ff;
   assign rsp_if.display_value    = rsp_disp_ff;
   assign rsp_if.window_refreshed = rsp_ref_ff;

`ifndef ASSERT_OFF
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DECIDE))
      else $error("accepted item did not reach the decision step");

   a_wpos_range: assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= PW'(WINDOW_LEN - 1))
      else $error("write position beyond the window");

   a_streak_limit: assert property (@(posedge clock) disable iff (reset)
      (rise_ff <= SW'(STREAK_LIMIT)) && (fall_ff <= SW'(STREAK_LIMIT))
      && (ret_ff <= SW'(STREAK_LIMIT)))
      else $error("streak counter passed its limit");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG_GO) |-> (sum_ff <= SUM_W'(WINDOW_LEN) * SUM_W'(24'hFFFFFF)))
      else $error("running sum out of range");

   a_fill_flag: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FILL) && (fill_ff == '0)) |-> $past(do_fill))
      else $error("refill started without a streak overflow");
`endif

endmodule
